[rtl/core/tcw_pkg.sv]
package tcw_pkg;

    typedef enum logic [1:0] {
        CMD_PUT    = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_SETPOS = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    localparam logic [7:0]  BLANK_CHAR  = 8'h20;
    localparam logic [7:0]  LINE_FEED   = 8'h0A;
    localparam logic [7:0]  COLOR_RESET = 8'h07;
    localparam logic [15:0] CELL_RESET  = {COLOR_RESET, BLANK_CHAR};

    // one request as it arrives on the input channel
    typedef struct packed {
        logic [1:0] command;
        logic [7:0] char_code;
        logic [6:0] column;
        logic [4:0] row;
    } t_item;

    // one result as it leaves on the output channel
    typedef struct packed {
        logic [6:0]  cursor_column;
        logic [4:0]  cursor_row;
        logic [10:0] cursor_offset;
        logic        break_pending;
        logic [15:0] cell_value;
    } t_result;

    // classified request, coordinates already saturated
    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] char_code;
        logic       is_lf;
        logic [6:0] column;
        logic [4:0] row;
    } t_op;

    typedef struct packed {
        logic valid;
        logic full;
    } t_q_stat;

    typedef struct packed {
        logic init_busy;
    } t_back_stat;

endpackage

[rtl/core/tcw_front.sv]
module tcw_front #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                    start,
    output logic                    busy,
    input  tcw_pkg::t_item          i_item,
    input  tcw_pkg::t_q_stat        i_q_stat,
    input  tcw_pkg::t_back_stat     i_back_stat,
    output logic                    o_push,
    output tcw_pkg::t_op            o_op
);

    assign busy   = i_q_stat.full || i_back_stat.init_busy;
    assign o_push = start && !busy;

    always_comb begin
        o_op.cmd       = tcw_pkg::t_cmd'(i_item.command);
        o_op.char_code = i_item.char_code;
        o_op.is_lf     = (i_item.char_code == tcw_pkg::LINE_FEED);
        // saturate out-of-range coordinates to the last column / row
        if (int'(i_item.column) >= COLUMNS) begin
            o_op.column = 7'(COLUMNS - 1);
        end else begin
            o_op.column = i_item.column;
        end
        if (int'(i_item.row) >= ROWS) begin
            o_op.row = 5'(ROWS - 1);
        end else begin
            o_op.row = i_item.row;
        end
    end

endmodule

[rtl/core/tcw_queue.sv]
module tcw_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tcw_pkg::t_op      i_op,
    input  logic              i_pop,
    output tcw_pkg::t_op      o_head,
    output tcw_pkg::t_q_stat  o_stat
);

    tcw_pkg::t_op r_ent [2];
    logic         r_wr_ptr;
    logic         r_rd_ptr;
    logic [1:0]   r_count;

    assign o_head       = r_ent[r_rd_ptr];
    assign o_stat.valid = (r_count != 2'd0);
    assign o_stat.full  = (r_count == 2'd2);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

[rtl/core/tcw_back.sv]
module tcw_back #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tcw_pkg::t_op         i_op,
    input  tcw_pkg::t_q_stat     i_q_stat,
    output logic                 o_pop,
    input  logic [7:0]           i_text_color,
    output tcw_pkg::t_back_stat  o_stat,
    output logic                 o_res_valid,
    output tcw_pkg::t_result     o_res
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);

    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
    localparam logic [AW-1:0] COPY_END  = AW'(CELLS - COLUMNS);
    localparam logic [AW-1:0] ROW_STEP  = AW'(COLUMNS);
    localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
    localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_SCROLL,
        S_BLANK,
        S_PUTEND,
        S_READ
    } t_state;

    function automatic logic [AW-1:0] lin(input logic [RW-1:0] r, input logic [CW-1:0] c);
        return AW'(AW'(r) * ROW_STEP) + AW'(c);
    endfunction

    logic [15:0] r_mem [CELLS];
    logic [15:0] r_rd_data;

    t_state           r_state,    n_state;
    logic             r_init,     n_init;
    logic [RW-1:0]    r_row,      n_row;
    logic [CW-1:0]    r_col,      n_col;
    logic             r_pend,     n_pend;
    logic [AW-1:0]    r_idx,      n_idx;
    logic             r_copy_vld, n_copy_vld;
    logic [AW-1:0]    r_copy_dst, n_copy_dst;
    logic [15:0]      r_blank,    n_blank;
    tcw_pkg::t_op     r_op,       n_op;
    logic             r_res_vld,  n_res_vld;
    tcw_pkg::t_result r_res,      n_res;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wr_data;
    logic [AW-1:0] rd_addr;
    logic [15:0]   rd_cell;

    tcw_pkg::t_op  cur_op;
    logic [RW-1:0] base_row;
    logic [CW-1:0] base_col;
    logic [CW-1:0] put_col;
    logic          put_pend;

    // where the character lands once any pending newline is done
    always_comb begin
        if (r_state == S_PUTEND) begin
            cur_op   = r_op;
            base_row = LAST_ROW;
            base_col = '0;
        end else begin
            cur_op = i_op;
            if (r_pend) begin
                base_row = r_row + RW'(1);
                base_col = '0;
            end else begin
                base_row = r_row;
                base_col = r_col;
            end
        end
        if (cur_op.is_lf) begin
            put_col  = base_col;
            put_pend = 1'b1;
        end else if (base_col == LAST_COL) begin
            put_col  = '0;
            put_pend = 1'b1;
        end else begin
            put_col  = base_col + CW'(1);
            put_pend = 1'b0;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_init     = r_init;
        n_row      = r_row;
        n_col      = r_col;
        n_pend     = r_pend;
        n_idx      = r_idx;
        n_copy_vld = 1'b0;
        n_copy_dst = r_copy_dst;
        n_blank    = r_blank;
        n_op       = r_op;
        n_res_vld  = 1'b0;
        n_res      = r_res;
        o_pop      = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = lin(base_row, base_col);
        wr_data    = {i_text_color, cur_op.char_code};
        rd_addr    = r_idx + ROW_STEP;
        rd_cell    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_q_stat.valid) begin
                    o_pop = 1'b1;
                    n_op  = i_op;
                    unique case (i_op.cmd)
                        tcw_pkg::CMD_PUT: begin
                            if (r_pend && (r_row == LAST_ROW)) begin
                                n_state = S_SCROLL;
                                n_idx   = '0;
                            end else begin
                                wr_en     = !i_op.is_lf;
                                n_row     = base_row;
                                n_col     = put_col;
                                n_pend    = put_pend;
                                n_res_vld = 1'b1;
                            end
                        end
                        tcw_pkg::CMD_CLEAR: begin
                            n_state = S_CLEAR;
                            n_idx   = '0;
                            n_blank = {i_text_color, tcw_pkg::BLANK_CHAR};
                        end
                        tcw_pkg::CMD_SETPOS: begin
                            n_col     = CW'(i_op.column);
                            n_row     = RW'(i_op.row);
                            n_res_vld = 1'b1;
                        end
                        tcw_pkg::CMD_READ: begin
                            rd_addr = lin(RW'(i_op.row), CW'(i_op.column));
                            n_state = S_READ;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_idx;
                wr_data = r_blank;
                if (r_idx == LAST_CELL) begin
                    n_state   = S_IDLE;
                    n_idx     = '0;
                    n_row     = '0;
                    n_col     = '0;
                    n_pend    = 1'b0;
                    n_init    = 1'b0;
                    n_res_vld = !r_init;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            S_SCROLL: begin
                // read one row ahead, write the registered data in the following cycle
                wr_en   = r_copy_vld;
                wr_addr = r_copy_dst;
                wr_data = r_rd_data;
                if (r_idx != COPY_END) begin
                    n_copy_vld = 1'b1;
                    n_copy_dst = r_idx;
                    n_idx      = r_idx + AW'(1);
                end else begin
                    n_state = S_BLANK;
                end
            end
            S_BLANK: begin
                wr_en   = 1'b1;
                wr_addr = r_idx;
                wr_data = {i_text_color, tcw_pkg::BLANK_CHAR};
                if (r_idx == LAST_CELL) begin
                    n_state = S_PUTEND;
                    n_idx   = '0;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            S_PUTEND: begin
                wr_en     = !r_op.is_lf;
                n_row     = base_row;
                n_col     = put_col;
                n_pend    = put_pend;
                n_res_vld = 1'b1;
                n_state   = S_IDLE;
            end
            S_READ: begin
                rd_cell   = r_rd_data;
                n_res_vld = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (n_res_vld) begin
            n_res.cursor_column = 7'(n_col);
            n_res.cursor_row    = 5'(n_row);
            n_res.cursor_offset = 11'(lin(n_row, n_col));
            n_res.break_pending = n_pend;
            n_res.cell_value    = rd_cell;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_init     <= 1'b1;
            r_row      <= '0;
            r_col      <= '0;
            r_pend     <= 1'b0;
            r_idx      <= '0;
            r_copy_vld <= 1'b0;
            r_blank    <= tcw_pkg::CELL_RESET;
            r_res_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_init     <= n_init;
            r_row      <= n_row;
            r_col      <= n_col;
            r_pend     <= n_pend;
            r_idx      <= n_idx;
            r_copy_vld <= n_copy_vld;
            r_blank    <= n_blank;
            r_res_vld  <= n_res_vld;
        end
        r_copy_dst <= n_copy_dst;
        r_op       <= n_op;
        r_res      <= n_res;
    end

    assign o_stat.init_busy = r_init;
    assign o_res_valid      = r_res_vld;
    assign o_res            = r_res;

endmodule

[rtl/core/text_terminal_char_writer.sv]
// text terminal engine: a COLUMNS x ROWS screen of 16-bit cells (char low, attribute high)
// with a cursor and a pending line break.
// requests: one command per request on i_item, taken at a clock edge with start high and
// busy low. a two-entry queue sits between the decode front and the execution back end,
// so requests keep being taken while the back end works, until the queue fills.
// results: exactly one per request, in order, on o_res for a single cycle marked by
// o_res_valid. the receiver cannot stall, so results are never held.
// read cell goes through one registered screen memory read. a put that scrolls copies or
// blanks one cell per cycle through the single write port, and clear blanks every cell.
// put and set position sustain one per cycle while no scroll, clear or read holds the back
// end; the back end takes no new request until a read cell has formed its result.
// text_color sits at byte address 0 of the apb port, reset value 7; write it only while
// no request is outstanding.
// reset: cursor home, no pending break, then a pass fills every cell with a space in
// color 7; busy stays high during that pass.
module text_terminal_char_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  tcw_pkg::t_item          i_item,
    output logic                    o_res_valid,
    output tcw_pkg::t_result        o_res,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic [7:0] r_text_color;

    tcw_pkg::t_op        front_op;
    tcw_pkg::t_op        head_op;
    tcw_pkg::t_q_stat    q_stat;
    tcw_pkg::t_back_stat back_stat;
    logic                push;
    logic                pop;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {24'd0, r_text_color} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color <= tcw_pkg::COLOR_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
            r_text_color <= pwdata[7:0];
        end
    end

    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .i_q_stat    (q_stat),
        .i_back_stat (back_stat),
        .o_push      (push),
        .o_op        (front_op)
    );

    tcw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (front_op),
        .i_pop   (pop),
        .o_head  (head_op),
        .o_stat  (q_stat)
    );

    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (head_op),
        .i_q_stat     (q_stat),
        .o_pop        (pop),
        .i_text_color (r_text_color),
        .o_stat       (back_stat),
        .o_res_valid  (o_res_valid),
        .o_res        (o_res)
    );

endmodule

[dv/text_terminal_char_writer_checker.sv]
`timescale 1ns / 1ps

module text_terminal_char_writer_checker
    import tcw_pkg::*;
#(
    parameter int         COLUMNS         = 80,
    parameter int         ROWS            = 25,
    parameter logic [2:0] TEXT_COLOR_ADDR = 3'd0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  t_item       i_item,
    input  logic        i_res_valid,
    input  t_result     i_res,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_errors,
    output int          o_outstanding
);

    localparam int CELLS = COLUMNS * ROWS;

    logic [15:0] screen [CELLS];
    int unsigned cur_row;
    int unsigned cur_col;
    bit          brk_pending;
    logic [7:0]  color;
    t_result     cursor_reports[$];
    int          err_cnt = 0;

    task automatic blank_screen();
        for (int i = 0; i < CELLS; i++) begin
            screen[i] = {color, BLANK_CHAR};
        end
        cur_row     = 0;
        cur_col     = 0;
        brk_pending = 1'b0;
    endtask

    // newline on the bottom row scrolls everything up one row
    task automatic advance_line();
        cur_row++;
        if (cur_row >= ROWS) begin
            cur_row = ROWS - 1;
            for (int i = 0; i < CELLS - COLUMNS; i++) begin
                screen[i] = screen[i + COLUMNS];
            end
            for (int x = 0; x < COLUMNS; x++) begin
                screen[CELLS - COLUMNS + x] = {color, BLANK_CHAR};
            end
        end
        cur_col     = 0;
        brk_pending = 1'b0;
    endtask

    task automatic run_terminal_cmd(input t_item it, output t_result rep);
        int unsigned c;
        int unsigned r;
        int unsigned off;
        logic [15:0] rd_cell;
        rd_cell = '0;
        c = (it.column >= COLUMNS) ? COLUMNS - 1 : it.column;
        r = (it.row >= ROWS) ? ROWS - 1 : it.row;
        case (t_cmd'(it.command))
            CMD_PUT: begin
                if (brk_pending) advance_line();
                if (it.char_code == LINE_FEED) begin
                    brk_pending = 1'b1;
                end else begin
                    screen[cur_row * COLUMNS + cur_col] = {color, it.char_code};
                    cur_col++;
                    if (cur_col >= COLUMNS) begin
                        cur_col     = 0;
                        brk_pending = 1'b1;
                    end
                end
            end
            CMD_CLEAR: blank_screen();
            CMD_SETPOS: begin
                cur_col = c;
                cur_row = r;
            end
            default: rd_cell = screen[r * COLUMNS + c];
        endcase
        off               = cur_row * COLUMNS + cur_col;
        rep.cursor_column = cur_col[6:0];
        rep.cursor_row    = cur_row[4:0];
        rep.cursor_offset = off[10:0];
        rep.break_pending = brk_pending;
        rep.cell_value    = rd_cell;
    endtask

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, exp_v, act_v);
            err_cnt++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_result exp_rep;
        t_result pred;
        if (!i_rst_n) begin
            color = COLOR_RESET;
            blank_screen();
            cursor_reports.delete();
        end else begin
            if (i_res_valid) begin
                if (cursor_reports.size() == 0) begin
                    $display("%0t: result with none expected, actual 0x%0h", $time, i_res);
                    err_cnt++;
                end else begin
                    exp_rep = cursor_reports.pop_front();
                    check_field("cursor_column", exp_rep.cursor_column, i_res.cursor_column);
                    check_field("cursor_row", exp_rep.cursor_row, i_res.cursor_row);
                    check_field("cursor_offset", exp_rep.cursor_offset, i_res.cursor_offset);
                    check_field("break_pending", exp_rep.break_pending, i_res.break_pending);
                    check_field("cell_value", exp_rep.cell_value, i_res.cell_value);
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready
                    && i_paddr[2] == TEXT_COLOR_ADDR[2]) begin
                color = i_pwdata[7:0];
            end
            if (i_start && !i_busy) begin
                run_terminal_cmd(i_item, pred);
                cursor_reports.push_back(pred);
            end
        end
        o_errors      <= err_cnt;
        o_outstanding <= cursor_reports.size();
    end

endmodule

[dv/text_terminal_char_writer_tb.sv]
`timescale 1ns / 1ps

module text_terminal_char_writer_tb;
    import tcw_pkg::*;

    localparam int         COLUMNS        = 80;
    localparam int         ROWS           = 25;
    localparam logic [2:0] REG_TEXT_COLOR = 3'd0;
    localparam int         PHASE_ITEMS    = 320;
    localparam int         QUIET_LIMIT    = 12000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_item       i_item;
    logic        o_res_valid;
    t_result     o_res;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          errors;
    int          outstanding;
    int          quiet_cycles = 0;
    int unsigned last_row = 0;

    text_terminal_char_writer #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_res_valid(o_res_valid),
        .o_res      (o_res),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    text_terminal_char_writer_checker #(
        .COLUMNS        (COLUMNS),
        .ROWS           (ROWS),
        .TEXT_COLOR_ADDR(REG_TEXT_COLOR)
    ) checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (i_item),
        .i_res_valid  (o_res_valid),
        .i_res        (o_res),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_errors     (errors),
        .o_outstanding(outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // no request, result or register write for too long means a hang
    always @(posedge i_clk) begin
        if ((start && !busy) || o_res_valid || (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("text_terminal_char_writer: mismatch");
            $finish;
        end
    end

    function automatic t_item make_req(t_cmd cmd, logic [7:0] ch, logic [6:0] col,
                                       logic [4:0] row);
        t_item it;
        it.command   = cmd;
        it.char_code = ch;
        it.column    = col;
        it.row       = row;
        return it;
    endfunction

    task automatic post_request(input t_item it);
        i_item <= it;
        start  <= 1'b1;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0 || busy);
    endtask

    task automatic write_text_color(input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_TEXT_COLOR;
        pwdata  <= {24'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic t_item random_request();
        t_item       it;
        int unsigned pick;
        pick         = $urandom_range(0, 99);
        it.char_code = 8'($urandom_range(0, 255));
        it.column    = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                                   : 7'($urandom_range(0, 79));
        it.row       = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                                   : 5'($urandom_range(0, 24));
        if (pick < 55) begin
            it.command = CMD_PUT;
            if ($urandom_range(0, 9) == 0) it.char_code = LINE_FEED;
        end else if (pick < 70) begin
            it.command = CMD_SETPOS;
            last_row   = (it.row >= ROWS) ? ROWS - 1 : it.row;
        end else if (pick < 97) begin
            it.command = CMD_READ;
            // half the reads go to the row of the last set position or clear
            if ($urandom_range(0, 1) == 0) it.row = last_row[4:0];
        end else begin
            it.command = CMD_CLEAR;
            last_row   = 0;
        end
        return it;
    endfunction

    task automatic run_random_phase(input int n, input bit idle_ok);
        int gap;
        for (int k = 0; k < n; k++) begin
            post_request(random_request());
            if (idle_ok && $urandom_range(0, 59) == 0) begin
                drain_results();
            end else if (idle_ok && $urandom_range(0, 3) == 0) begin
                start <= 1'b0;
                gap = $urandom_range(1, 7);
                repeat (gap) @(posedge i_clk);
            end
        end
        drain_results();
        repeat (4) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [7:0] colors [5];
        colors = '{8'h00, 8'hFF, 8'h1E, 8'h00, 8'h07};
        colors[3] = 8'($urandom_range(0, 255));

        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_item  <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // screen fill pass after reset
        do @(posedge i_clk); while (busy);

        // reset contents and saturated reads
        post_request(make_req(CMD_READ, 8'h00, 7'd0, 5'd0));
        post_request(make_req(CMD_READ, 8'hFF, 7'd127, 5'd31));
        // full row wraps and leaves a break pending
        post_request(make_req(CMD_SETPOS, 8'h00, 7'd78, 5'd0));
        post_request(make_req(CMD_PUT, 8'h41, 7'd0, 5'd0));
        post_request(make_req(CMD_PUT, 8'hFF, 7'd127, 5'd31));
        post_request(make_req(CMD_READ, 8'h00, 7'd79, 5'd0));
        // line feed while pending gives an empty line
        post_request(make_req(CMD_PUT, LINE_FEED, 7'd0, 5'd0));
        post_request(make_req(CMD_PUT, 8'h00, 7'd0, 5'd0));
        post_request(make_req(CMD_READ, 8'h00, 7'd0, 5'd2));
        // out-of-range position saturates, pending break kept
        post_request(make_req(CMD_SETPOS, 8'h00, 7'd100, 5'd30));
        post_request(make_req(CMD_PUT, 8'h80, 7'd0, 5'd0));
        post_request(make_req(CMD_SETPOS, 8'h00, 7'd5, 5'd31));
        // newline on the bottom row scrolls
        post_request(make_req(CMD_PUT, 8'h7F, 7'd0, 5'd0));
        post_request(make_req(CMD_READ, 8'h00, 7'd79, 5'd23));
        post_request(make_req(CMD_READ, 8'h00, 7'd0, 5'd24));
        post_request(make_req(CMD_PUT, LINE_FEED, 7'd0, 5'd0));
        post_request(make_req(CMD_PUT, 8'h55, 7'd0, 5'd0));
        post_request(make_req(CMD_READ, 8'h00, 7'd0, 5'd23));
        post_request(make_req(CMD_CLEAR, 8'h00, 7'd127, 5'd31));
        post_request(make_req(CMD_READ, 8'h00, 7'd0, 5'd24));
        post_request(make_req(CMD_SETPOS, 8'h00, 7'd0, 5'd0));
        post_request(make_req(CMD_READ, 8'h00, 7'd0, 5'd0));
        drain_results();
        repeat (4) @(posedge i_clk);

        for (int p = 0; p < 5; p++) begin
            write_text_color(colors[p]);
            if (p == 1) begin
                // clear with the new color before going random
                post_request(make_req(CMD_CLEAR, 8'h00, 7'd0, 5'd0));
                post_request(make_req(CMD_READ, 8'h00, 7'd79, 5'd24));
                drain_results();
            end
            run_random_phase(PHASE_ITEMS, p != 4);
        end

        drain_results();
        repeat (16) @(posedge i_clk);
        if (errors == 0 && outstanding == 0) begin
            $display("text_terminal_char_writer: match");
        end else begin
            $display("text_terminal_char_writer: mismatch");
        end
        $finish;
    end

endmodule
